### rtl/core/filtered_trace_ring_buffer_assert.svh
// Assertion macros used by the trace buffer checker.
`ifndef FILTERED_TRACE_RING_BUFFER_ASSERT_SVH
`define FILTERED_TRACE_RING_BUFFER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define FTRB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("trace buffer check failed");

// Next-cycle implication.
`define FTRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("trace buffer check failed");

`endif

### rtl/core/ftrb_pkg.sv
// Shared types, constants and helpers of the filtered trace ring buffer.
package ftrb_pkg;

   localparam int DEPTH      = 64;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int LIM_W      = $clog2(DEPTH + 1);

   localparam int CMD_W      = 2;
   localparam int TID_W      = 22;
   localparam int PID_W      = 22;
   localparam int STATE_W    = 16;
   localparam int COUNT_W    = 64;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 22;

   // request commands
   localparam logic [CMD_W-1:0] CMD_RECORD = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd2;

   // trace modes
   localparam logic [MODE_W-1:0] MODE_OFF = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SEL = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ALL = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TRACE_MODE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRACE_PID  = 1'b1;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [TID_W-1:0]   event_tid;
      logic [PID_W-1:0]   event_pid;
      logic [STATE_W-1:0] event_state;
   } req_type;

   typedef struct packed {
      logic [TID_W-1:0]   out_tid;
      logic [PID_W-1:0]   out_pid;
      logic [STATE_W-1:0] out_state;
      logic [COUNT_W-1:0] event_count;
      logic               empty_res;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [TID_W-1:0]   tid;
      logic [PID_W-1:0]   pid;
      logic [STATE_W-1:0] state;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   // one bit per slot below lim
   function automatic logic [DEPTH-1:0] below_mask(input logic [LIM_W-1:0] lim);
      logic [DEPTH-1:0] m;
      for (int i = 0; i < DEPTH; i++) begin
         m[i] = (LIM_W'(i) < lim);
      end
      return m;
   endfunction

endpackage

### rtl/core/ftrb_ram.sv
// Single-port-write, single-port-read record memory with registered read data.
module ftrb_ram #(
   parameter int ADDR_W = 6,
   parameter int DATA_W = 60
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/filtered_trace_ring_buffer.sv
// Filtered trace ring buffer: top level with command decode, dump walker and output stage.
//
// Captures state-change events into a DEPTH-entry ring held in a synchronous
// RAM. On a record request, when trace_mode is 2, or 1 with event_tid equal to
// trace_pid, the event lands in slot (count mod DEPTH), its cleared mark drops
// and the 64-bit event count bumps; mode 0 or 3 drops it.
// A clear request marks every slot written so far as cleared (flag bits
// live in flops); the count is kept. A dump request walks
// the retained slots oldest first and returns one response per uncleared slot,
// each carrying the event count seen at the dump, with last set on the final
// one; a dump that finds nothing returns a single response with empty_res and
// last set and zero record fields. Intake stalls while a dump walks: a skipped
// cleared slot just advances the walk, and each returned record is read from
// the RAM and then loaded into the output register; response backpressure
// holds the walk. The walk stops after the last retained slot. Records and
// clears run one per cycle while no dump walks. The output register
// lets the next request in while the final response of a dump waits.
// Unknown command codes are accepted and ignored. No clearing pass after reset:
// the record RAM needs none since only written slots are ever read.
module filtered_trace_ring_buffer
   import ftrb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,

   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WALK = 2'b10
   } state_type;

   state_type          state_ff,      state_in;
   logic [MODE_W-1:0]  mode_ff,       mode_in;
   logic [TID_W-1:0]   sel_tid_ff,    sel_tid_in;
   logic [COUNT_W-1:0] total_ff,      total_in;
   logic [DEPTH-1:0]   cleared_ff,    cleared_in;
   logic [DEPTH-1:0]   pending_ff,    pending_in;   // retained slots left in this dump
   logic [IDX_W-1:0]   ptr_ff,        ptr_in;
   logic [COUNT_W-1:0] dump_count_ff, dump_count_in;
   logic               pend_ff,       pend_in;      // RAM read in flight
   logic               pend_last_ff,  pend_last_in;
   logic               rsp_valid_ff,  rsp_valid_in;
   rsp_type            rsp_data_ff,   rsp_data_in;

   logic             req_fire;
   logic             take;
   logic [LIM_W-1:0] lim;
   logic [DEPTH-1:0] span_mask;
   logic [IDX_W-1:0] wr_idx;
   logic             out_free;
   logic [DEPTH-1:0] rest;
   logic [IDX_W-1:0] ptr_next;
   logic             ram_we;
   logic             ram_re;
   logic             emit_empty;
   rec_type          wr_rec;
   rec_type          rd_rec;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   assign take = (mode_ff == MODE_ALL) ||
                 ((mode_ff == MODE_SEL) && (req_data.event_tid == sel_tid_ff));

   // written slots: min(count, DEPTH); ring position is count mod DEPTH
   assign lim       = (total_ff >= COUNT_W'(DEPTH)) ? LIM_W'(DEPTH) : total_ff[LIM_W-1:0];
   assign span_mask = below_mask(lim);
   assign wr_idx    = total_ff[IDX_W-1:0];

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign rest     = pending_ff & ~(DEPTH'(1) << ptr_ff);
   assign ptr_next = (ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : ptr_ff + 1'b1;

   assign wr_rec.tid   = req_data.event_tid;
   assign wr_rec.pid   = req_data.event_pid;
   assign wr_rec.state = req_data.event_state;

   // config writes
   always_comb begin
      mode_in    = mode_ff;
      sel_tid_in = sel_tid_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TRACE_MODE: mode_in    = csr_wdata[MODE_W-1:0];
            CSR_TRACE_PID:  sel_tid_in = csr_wdata[TID_W-1:0];
            default: ;
         endcase
      end
   end

   // command decode and dump walker
   always_comb begin
      state_in      = state_ff;
      total_in      = total_ff;
      cleared_in    = cleared_ff;
      pending_in    = pending_ff;
      ptr_in        = ptr_ff;
      dump_count_in = dump_count_ff;
      pend_in       = 1'b0;
      pend_last_in  = pend_last_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      emit_empty    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_data.cmd)
                  CMD_RECORD: begin
                     if (take) begin
                        ram_we             = 1'b1;
                        cleared_in[wr_idx] = 1'b0;
                        total_in           = total_ff + 1'b1;
                     end
                  end
                  CMD_CLEAR: begin
                     cleared_in = cleared_ff | span_mask;
                  end
                  CMD_DUMP: begin
                     pending_in    = ~cleared_ff & span_mask;
                     // oldest slot when full, 0 otherwise
                     ptr_in        = (total_ff > COUNT_W'(DEPTH)) ? wr_idx : '0;
                     dump_count_in = total_ff;
                     state_in      = ST_WALK;
                  end
                  default: ;
               endcase
            end
         end
         ST_WALK: begin
            if (pending_ff == '0) begin
               // nothing retained: single empty response
               if (!pend_ff && out_free) begin
                  emit_empty = 1'b1;
                  state_in   = ST_IDLE;
               end
            end else if (pending_ff[ptr_ff]) begin
               if (!pend_ff && out_free) begin
                  ram_re       = 1'b1;
                  pend_in      = 1'b1;
                  pend_last_in = (rest == '0);
                  pending_in   = rest;
                  ptr_in       = ptr_next;
                  if (rest == '0) begin
                     state_in = ST_IDLE;
                  end
               end
            end else begin
               ptr_in = ptr_next;   // cleared slot, skip
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (pend_ff) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.out_tid     = rd_rec.tid;
         rsp_data_in.out_pid     = rd_rec.pid;
         rsp_data_in.out_state   = rd_rec.state;
         rsp_data_in.event_count = dump_count_ff;
         rsp_data_in.empty_res   = 1'b0;
         rsp_data_in.last        = pend_last_ff;
      end else if (emit_empty) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.out_tid     = '0;
         rsp_data_in.out_pid     = '0;
         rsp_data_in.out_state   = '0;
         rsp_data_in.event_count = dump_count_ff;
         rsp_data_in.empty_res   = 1'b1;
         rsp_data_in.last        = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_OFF;
         sel_tid_ff   <= '0;
         total_ff     <= '0;
         cleared_ff   <= '0;
         pending_ff   <= '0;
         ptr_ff       <= '0;
         pend_ff      <= 1'b0;
         pend_last_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         sel_tid_ff   <= sel_tid_in;
         total_ff     <= total_in;
         cleared_ff   <= cleared_in;
         pending_ff   <= pending_in;
         ptr_ff       <= ptr_in;
         pend_ff      <= pend_in;
         pend_last_ff <= pend_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dump_count_ff <= dump_count_in;
      rsp_data_ff   <= rsp_data_in;
   end

   ftrb_ram #(
      .ADDR_W (IDX_W),
      .DATA_W (REC_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_idx),
      .wr_data (wr_rec),
      .rd_en   (ram_re),
      .rd_addr (ptr_ff),
      .rd_data (rd_rec)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/core/ftrb_checker.sv
// Port-level checker for the filtered trace ring buffer, with its bind.
`include "filtered_trace_ring_buffer_assert.svh"

module ftrb_checker
   import ftrb_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a non-final response means the dump is still walking
   `FTRB_ASSERT_NOW(a_walk_stalls_intake, clock, reset, rsp_valid && !rsp_data.last, !req_ready)

   // an empty dump answer is final and carries no record
   `FTRB_ASSERT_NOW(a_empty_is_last, clock, reset, rsp_valid && rsp_data.empty_res,
      rsp_data.last && (rsp_data.out_tid == '0) && (rsp_data.out_pid == '0) &&
      (rsp_data.out_state == '0))

   // a dump always closes intake in the cycle after it is taken
   `FTRB_ASSERT_NEXT(a_dump_closes_intake, clock, reset,
      req_valid && req_ready && (req_data.cmd == CMD_DUMP), !req_ready)

   // stalled response holds
   `FTRB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_data))

endmodule

bind filtered_trace_ring_buffer ftrb_checker u_checker (.*);
